// ===== hdl/hfd_pkg.sv =====
// shared types and constants of the http/2 frame deframer
`default_nettype none
package hfd_pkg;

	localparam int DATA_W      = 8;
	localparam int LEN_W       = 24;
	localparam int STREAM_W    = 31;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 24;
	localparam int QUEUE_DEPTH = 4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PREFACE_REQ = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME   = 2'd1;

	typedef enum logic [2:0] {
		ST_CONTINUE    = 3'd0,
		ST_READY       = 3'd1,
		ST_PREFACE_BAD = 3'd2,
		ST_BAD_FRAME   = 3'd3,
		ST_FRAME_SIZE  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		STG_PREFACE = 2'd0,
		STG_HEADER  = 2'd1,
		STG_PAYLOAD = 2'd2
	} stage_t;

	typedef struct packed {
		status_t               status;
		logic                  payload_valid;
		logic [DATA_W-1:0]     payload_byte;
		logic [LEN_W-1:0]      payload_offset;
		logic [LEN_W-1:0]      frame_length;
		logic [DATA_W-1:0]     frame_type;
		logic [DATA_W-1:0]     frame_flags;
		logic [STREAM_W-1:0]   frame_stream;
	} result_t;

endpackage
`default_nettype wire

// ===== hdl/hfd_front.sv =====
// front end: preface check, header gathering and checks, payload tagging
`default_nettype none
module hfd_front (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_fire,
	input  wire logic [hfd_pkg::DATA_W-1:0]       data_byte,
	input  wire logic                             cfg_we,
	input  wire logic [hfd_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [hfd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output hfd_pkg::result_t                      res
);

	localparam logic [7:0] TYPE_DATA          = 8'd0;
	localparam logic [7:0] TYPE_HEADERS       = 8'd1;
	localparam logic [7:0] TYPE_PRIORITY      = 8'd2;
	localparam logic [7:0] TYPE_RST_STREAM    = 8'd3;
	localparam logic [7:0] TYPE_SETTINGS      = 8'd4;
	localparam logic [7:0] TYPE_PUSH_PROMISE  = 8'd5;
	localparam logic [7:0] TYPE_PING          = 8'd6;
	localparam logic [7:0] TYPE_GOAWAY        = 8'd7;
	localparam logic [7:0] TYPE_WINDOW_UPDATE = 8'd8;
	localparam logic [7:0] TYPE_CONTINUATION  = 8'd9;

	localparam logic [4:0]  PREFACE_LAST = 5'd23;
	localparam logic [3:0]  HDR_LAST     = 4'd8;
	localparam logic [23:0] DEFAULT_MAX  = 24'd16384;

	function automatic logic [7:0] preface_char(input logic [4:0] idx);
		logic [7:0] c;
		case (idx)
			5'd0:  c = 8'h50;
			5'd1:  c = 8'h52;
			5'd2:  c = 8'h49;
			5'd3:  c = 8'h20;
			5'd4:  c = 8'h2a;
			5'd5:  c = 8'h20;
			5'd6:  c = 8'h48;
			5'd7:  c = 8'h54;
			5'd8:  c = 8'h54;
			5'd9:  c = 8'h50;
			5'd10: c = 8'h2f;
			5'd11: c = 8'h32;
			5'd12: c = 8'h2e;
			5'd13: c = 8'h30;
			5'd14: c = 8'h0d;
			5'd15: c = 8'h0a;
			5'd16: c = 8'h0d;
			5'd17: c = 8'h0a;
			5'd18: c = 8'h53;
			5'd19: c = 8'h4d;
			5'd20: c = 8'h0d;
			5'd21: c = 8'h0a;
			5'd22: c = 8'h0d;
			5'd23: c = 8'h0a;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// add two residues mod 3
	function automatic logic [1:0] mod3_add(input logic [1:0] a, input logic [1:0] b);
		logic [2:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= 3'd3)
			s = s - 3'd3;
		return s[1:0];
	endfunction

	// byte mod 3: base-4 digits all weigh 1 mod 3
	function automatic logic [1:0] mod3_byte(input logic [7:0] b);
		logic [1:0] acc;
		acc = 2'd0;
		for (int k = 0; k < 4; k++)
			acc = mod3_add(acc, (b[2*k +: 2] == 2'd3) ? 2'd0 : b[2*k +: 2]);
		return acc;
	endfunction

	hfd_pkg::stage_t                  stage_q, stage_d;
	logic [4:0]                       pc_q, pc_d;
	logic [3:0]                       hc_q, hc_d;
	logic [hfd_pkg::LEN_W-1:0]        hlen_q, hlen_d;
	logic [7:0]                       htype_q, htype_d;
	logic [7:0]                       hflags_q, hflags_d;
	logic [hfd_pkg::STREAM_W-1:0]     hstream_q, hstream_d;
	logic [1:0]                       r3_q, r3_d;
	logic [hfd_pkg::LEN_W-1:0]        pcnt_q, pcnt_d;
	logic [hfd_pkg::LEN_W-1:0]        len_q, len_d;
	logic [7:0]                       type_q, type_d;
	logic [7:0]                       flags_q, flags_d;
	logic [hfd_pkg::STREAM_W-1:0]     stream_q, stream_d;
	hfd_pkg::status_t                 err_q, err_d;
	logic                             prereq_q, prereq_d;
	logic [hfd_pkg::LEN_W-1:0]        maxfs_q, maxfs_d;

	logic [hfd_pkg::STREAM_W-1:0]     new_stream;
	logic [hfd_pkg::LEN_W-1:0]        limit;
	logic [hfd_pkg::LEN_W-1:0]        pcnt_inc;
	logic                             conn_type, strm_type, stream_zero;
	hfd_pkg::status_t                 check;

	assign new_stream  = {hstream_q[hfd_pkg::STREAM_W-1:8], data_byte};
	assign limit       = (maxfs_q == '0) ? DEFAULT_MAX : maxfs_q;
	assign pcnt_inc    = pcnt_q + 24'd1;
	assign stream_zero = (new_stream == '0);
	assign conn_type   = (htype_q == TYPE_SETTINGS) || (htype_q == TYPE_PING) ||
	                     (htype_q == TYPE_GOAWAY);
	assign strm_type   = (htype_q == TYPE_DATA) || (htype_q == TYPE_HEADERS) ||
	                     (htype_q == TYPE_PRIORITY) || (htype_q == TYPE_RST_STREAM) ||
	                     (htype_q == TYPE_PUSH_PROMISE) || (htype_q == TYPE_CONTINUATION);

	// header checks on the ninth byte, first failing rule wins
	always_comb begin
		check = hfd_pkg::ST_CONTINUE;
		if (hlen_q > limit) begin
			check = hfd_pkg::ST_FRAME_SIZE;
		end else if (conn_type && !stream_zero) begin
			check = hfd_pkg::ST_BAD_FRAME;
		end else if (strm_type && stream_zero) begin
			check = hfd_pkg::ST_BAD_FRAME;
		end else begin
			case (htype_q)
				TYPE_PING: begin
					if (hlen_q != 24'd8) check = hfd_pkg::ST_FRAME_SIZE;
				end
				TYPE_WINDOW_UPDATE, TYPE_RST_STREAM: begin
					if (hlen_q != 24'd4) check = hfd_pkg::ST_FRAME_SIZE;
				end
				TYPE_PRIORITY: begin
					if (hlen_q != 24'd5) check = hfd_pkg::ST_FRAME_SIZE;
				end
				TYPE_SETTINGS: begin
					// ack must be empty, otherwise a multiple of 6 (even and mod 3 zero)
					if (hflags_q[0] && hlen_q != '0)
						check = hfd_pkg::ST_FRAME_SIZE;
					else if (hlen_q[0] || r3_q != 2'd0)
						check = hfd_pkg::ST_FRAME_SIZE;
				end
				TYPE_GOAWAY: begin
					if (hlen_q < 24'd8) check = hfd_pkg::ST_FRAME_SIZE;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		stage_d   = stage_q;
		pc_d      = pc_q;
		hc_d      = hc_q;
		hlen_d    = hlen_q;
		htype_d   = htype_q;
		hflags_d  = hflags_q;
		hstream_d = hstream_q;
		r3_d      = r3_q;
		pcnt_d    = pcnt_q;
		len_d     = len_q;
		type_d    = type_q;
		flags_d   = flags_q;
		stream_d  = stream_q;
		err_d     = err_q;
		prereq_d  = prereq_q;
		maxfs_d   = maxfs_q;

		res.status         = hfd_pkg::ST_CONTINUE;
		res.payload_valid  = 1'b0;
		res.payload_byte   = '0;
		res.payload_offset = '0;

		if (cfg_we) begin
			case (cfg_idx)
				hfd_pkg::REG_PREFACE_REQ: begin
					prereq_d  = cfg_wdata[0];
					stage_d   = cfg_wdata[0] ? hfd_pkg::STG_PREFACE : hfd_pkg::STG_HEADER;
					pc_d      = '0;
					hc_d      = '0;
					hlen_d    = '0;
					htype_d   = '0;
					hflags_d  = '0;
					hstream_d = '0;
					r3_d      = '0;
					pcnt_d    = '0;
					len_d     = '0;
					type_d    = '0;
					flags_d   = '0;
					stream_d  = '0;
					err_d     = hfd_pkg::ST_CONTINUE;
				end
				hfd_pkg::REG_MAX_FRAME: begin
					maxfs_d = cfg_wdata[hfd_pkg::LEN_W-1:0];
				end
				default: ;
			endcase
		end else if (in_fire) begin
			if (err_q != hfd_pkg::ST_CONTINUE) begin
				res.status = err_q;
			end else begin
				case (stage_q)
					hfd_pkg::STG_PREFACE: begin
						if (data_byte != preface_char(pc_q)) begin
							err_d      = hfd_pkg::ST_PREFACE_BAD;
							res.status = hfd_pkg::ST_PREFACE_BAD;
						end else begin
							pc_d = pc_q + 5'd1;
							if (pc_q == PREFACE_LAST) begin
								stage_d = hfd_pkg::STG_HEADER;
								hc_d    = '0;
							end
						end
					end
					hfd_pkg::STG_PAYLOAD: begin
						res.payload_valid  = 1'b1;
						res.payload_byte   = data_byte;
						res.payload_offset = pcnt_q;
						pcnt_d             = pcnt_inc;
						if (pcnt_inc >= len_q) begin
							stage_d    = hfd_pkg::STG_HEADER;
							hc_d       = '0;
							res.status = hfd_pkg::ST_READY;
						end
					end
					hfd_pkg::STG_HEADER: begin
						hc_d = hc_q + 4'd1;
						case (hc_q)
							4'd0: begin
								hlen_d[23:16] = data_byte;
								r3_d          = mod3_byte(data_byte);
							end
							4'd1: begin
								hlen_d[15:8] = data_byte;
								r3_d         = mod3_add(r3_q, mod3_byte(data_byte));
							end
							4'd2: begin
								hlen_d[7:0] = data_byte;
								r3_d        = mod3_add(r3_q, mod3_byte(data_byte));
							end
							4'd3: htype_d  = data_byte;
							4'd4: hflags_d = data_byte;
							4'd5: hstream_d[30:24] = data_byte[6:0];
							4'd6: hstream_d[23:16] = data_byte;
							4'd7: hstream_d[15:8]  = data_byte;
							HDR_LAST: begin
								hstream_d[7:0] = data_byte;
								hc_d           = '0;
								len_d          = hlen_q;
								type_d         = htype_q;
								flags_d        = hflags_q;
								stream_d       = new_stream;
								pcnt_d         = '0;
								if (check != hfd_pkg::ST_CONTINUE) begin
									err_d      = check;
									res.status = check;
								end else if (hlen_q == '0) begin
									res.status = hfd_pkg::ST_READY;
								end else begin
									stage_d = hfd_pkg::STG_PAYLOAD;
								end
							end
							default: hc_d = '0;
						endcase
					end
					default: ;
				endcase
			end
		end

		res.frame_length = len_d;
		res.frame_type   = type_d;
		res.frame_flags  = flags_d;
		res.frame_stream = stream_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q   <= hfd_pkg::STG_HEADER;
			pc_q      <= '0;
			hc_q      <= '0;
			hlen_q    <= '0;
			htype_q   <= '0;
			hflags_q  <= '0;
			hstream_q <= '0;
			r3_q      <= '0;
			pcnt_q    <= '0;
			len_q     <= '0;
			type_q    <= '0;
			flags_q   <= '0;
			stream_q  <= '0;
			err_q     <= hfd_pkg::ST_CONTINUE;
			prereq_q  <= 1'b0;
			maxfs_q   <= DEFAULT_MAX;
		end else begin
			stage_q   <= stage_d;
			pc_q      <= pc_d;
			hc_q      <= hc_d;
			hlen_q    <= hlen_d;
			htype_q   <= htype_d;
			hflags_q  <= hflags_d;
			hstream_q <= hstream_d;
			r3_q      <= r3_d;
			pcnt_q    <= pcnt_d;
			len_q     <= len_d;
			type_q    <= type_d;
			flags_q   <= flags_d;
			stream_q  <= stream_d;
			err_q     <= err_d;
			prereq_q  <= prereq_d;
			maxfs_q   <= maxfs_d;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/hfd_queue.sv =====
// result queue between the parser and the consumer
`default_nettype none
module hfd_queue #(
	parameter int Depth = hfd_pkg::QUEUE_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire hfd_pkg::result_t  wr_data,
	output logic                   full,
	input  wire logic              rd_en,
	output hfd_pkg::result_t       rd_data,
	output logic                   empty
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

	hfd_pkg::result_t mem_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  cnt_q;
	logic             do_wr, do_rd;

	assign full    = (cnt_q == CntW'(Depth));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + CntW'(1);
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - CntW'(1);
		end
	end

endmodule
`default_nettype wire

// ===== hdl/http2_frame_deframer_core.sv =====
// top level of the http/2 frame deframer: parser front end and result queue
//
// channel   direction  handshake          payload
// input     in         push / full        data_byte
// result    out        empty / pop        status, payload_valid, payload_byte,
//                                         payload_offset, frame_length,
//                                         frame_type, frame_flags, frame_stream
// config    in         cfg_we             cfg_idx, cfg_wdata
//
// one byte per clock while full is low: the parser decides each byte in the cycle it is pushed,
// including the header checks on the ninth header byte, and writes one result
// into the queue; a result can be popped the cycle after its byte is pushed.
// full rises only when QueueDepth results wait unpopped.
// reset leaves the preface check off and the size limit at 16384.
`default_nettype none
module http2_frame_deframer_core #(
	parameter int QueueDepth = hfd_pkg::QUEUE_DEPTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             push,
	output logic                                  full,
	input  wire logic [hfd_pkg::DATA_W-1:0]       data_byte,
	output logic                                  empty,
	input  wire logic                             pop,
	output logic [2:0]                            status,
	output logic                                  payload_valid,
	output logic [hfd_pkg::DATA_W-1:0]            payload_byte,
	output logic [hfd_pkg::LEN_W-1:0]             payload_offset,
	output logic [hfd_pkg::LEN_W-1:0]             frame_length,
	output logic [hfd_pkg::DATA_W-1:0]            frame_type,
	output logic [hfd_pkg::DATA_W-1:0]            frame_flags,
	output logic [hfd_pkg::STREAM_W-1:0]          frame_stream,
	input  wire logic                             cfg_we,
	input  wire logic [hfd_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [hfd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	hfd_pkg::result_t front_res;
	hfd_pkg::result_t head;
	logic             in_fire;

	assign in_fire = push && !full;

	hfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.data_byte (data_byte),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.res       (front_res)
	);

	hfd_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (in_fire),
		.wr_data (front_res),
		.full    (full),
		.rd_en   (pop),
		.rd_data (head),
		.empty   (empty)
	);

	assign status         = head.status;
	assign payload_valid  = head.payload_valid;
	assign payload_byte   = head.payload_byte;
	assign payload_offset = head.payload_offset;
	assign frame_length   = head.frame_length;
	assign frame_type     = head.frame_type;
	assign frame_flags    = head.frame_flags;
	assign frame_stream   = head.frame_stream;

endmodule
`default_nettype wire

// ===== bench/deframe_check_pkg.sv =====
// frame types, preface text and the expected-result tracker for the deframer bench
package deframe_check_pkg;
	timeunit 1ns;
	timeprecision 1ps;
	import hfd_pkg::*;

	localparam int unsigned PREFACE_LEN   = 24;
	localparam int unsigned HEADER_LEN    = 9;
	localparam int unsigned DEFAULT_LIMIT = 16384;
	localparam int unsigned PRINT_CAP     = 30;
	// "PRI * HTTP/2.0", cr lf cr lf, "SM", cr lf cr lf
	localparam logic [8*PREFACE_LEN-1:0] PREFACE_TEXT =
		192'h505249202a2048545450_2f322e300d0a0d0a534d_0d0a0d0a;
	localparam logic [7:0] FLAG_ACK = 8'h01;

	typedef enum logic [7:0] {
		FT_DATA          = 8'd0,
		FT_HEADERS       = 8'd1,
		FT_PRIORITY      = 8'd2,
		FT_RST_STREAM    = 8'd3,
		FT_SETTINGS      = 8'd4,
		FT_PUSH_PROMISE  = 8'd5,
		FT_PING          = 8'd6,
		FT_GOAWAY        = 8'd7,
		FT_WINDOW_UPDATE = 8'd8,
		FT_CONTINUATION  = 8'd9
	} frame_kind_t;

	function automatic logic [7:0] preface_char(int unsigned pos);
		return PREFACE_TEXT[8*(PREFACE_LEN-1-pos) +: 8];
	endfunction

	class frame_tracker;
		bit                    preface_on;
		logic [LEN_W-1:0]      size_limit;
		stage_t                stage;
		int unsigned           pre_idx;
		int unsigned           hdr_idx;
		logic [7:0]            header_buf [HEADER_LEN];
		logic [LEN_W-1:0]      pay_off;
		logic [LEN_W-1:0]      cur_len;
		logic [7:0]            cur_type;
		logic [7:0]            cur_flags;
		logic [STREAM_W-1:0]   cur_stream;
		status_t               sticky;
		result_t               expected_q [$];
		int unsigned           errors;

		function new();
			preface_on = 1'b0;
			size_limit = LEN_W'(DEFAULT_LIMIT);
			errors = 0;
			restart();
		endfunction

		function void restart();
			stage = preface_on ? STG_PREFACE : STG_HEADER;
			pre_idx = 0;
			hdr_idx = 0;
			foreach (header_buf[k]) header_buf[k] = '0;
			pay_off = '0;
			cur_len = '0;
			cur_type = '0;
			cur_flags = '0;
			cur_stream = '0;
			sticky = ST_CONTINUE;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			if (idx == REG_PREFACE_REQ) begin
				preface_on = value[0];
				restart();
			end else if (idx == REG_MAX_FRAME) begin
				size_limit = value[LEN_W-1:0];
			end
		endfunction

		function bit stuck();
			return sticky != ST_CONTINUE;
		endfunction

		function bit busy();
			return expected_q.size() != 0;
		endfunction

		function status_t header_verdict();
			logic [LEN_W-1:0] lim;
			bit conn_only;
			bit stream_only;
			lim = (size_limit == '0) ? LEN_W'(DEFAULT_LIMIT) : size_limit;
			conn_only = cur_type == FT_SETTINGS || cur_type == FT_PING || cur_type == FT_GOAWAY;
			stream_only = cur_type == FT_DATA || cur_type == FT_HEADERS ||
				cur_type == FT_PRIORITY || cur_type == FT_RST_STREAM ||
				cur_type == FT_PUSH_PROMISE || cur_type == FT_CONTINUATION;
			if (cur_len > lim) return ST_FRAME_SIZE;
			if (conn_only && cur_stream != '0) return ST_BAD_FRAME;
			if (stream_only && cur_stream == '0) return ST_BAD_FRAME;
			case (cur_type)
				FT_PING: if (cur_len != 8) return ST_FRAME_SIZE;
				FT_WINDOW_UPDATE, FT_RST_STREAM: if (cur_len != 4) return ST_FRAME_SIZE;
				FT_PRIORITY: if (cur_len != 5) return ST_FRAME_SIZE;
				FT_SETTINGS: begin
					if ((cur_flags & FLAG_ACK) != '0 && cur_len != '0) return ST_FRAME_SIZE;
					if (cur_len % 6 != 0) return ST_FRAME_SIZE;
				end
				FT_GOAWAY: if (cur_len < 8) return ST_FRAME_SIZE;
				default: ;
			endcase
			return ST_CONTINUE;
		endfunction

		// one accepted input transaction gives exactly one expected result
		function void note_byte(logic [7:0] b);
			result_t r;
			status_t verdict;
			r = '0;
			r.status = ST_CONTINUE;
			if (sticky != ST_CONTINUE) begin
				r.status = sticky;
			end else if (stage == STG_PREFACE) begin
				if (b != preface_char(pre_idx)) begin
					sticky = ST_PREFACE_BAD;
					r.status = sticky;
				end else begin
					pre_idx++;
					if (pre_idx >= PREFACE_LEN) begin
						stage = STG_HEADER;
						hdr_idx = 0;
					end
				end
			end else if (stage == STG_PAYLOAD) begin
				r.payload_valid = 1'b1;
				r.payload_byte = b;
				r.payload_offset = pay_off;
				pay_off = pay_off + 1'b1;
				if (pay_off >= cur_len) begin
					stage = STG_HEADER;
					hdr_idx = 0;
					r.status = ST_READY;
				end
			end else begin
				header_buf[hdr_idx] = b;
				hdr_idx++;
				if (hdr_idx >= HEADER_LEN) begin
					hdr_idx = 0;
					cur_len = {header_buf[0], header_buf[1], header_buf[2]};
					cur_type = header_buf[3];
					cur_flags = header_buf[4];
					// reserved bit of the stream id is dropped
					cur_stream = {header_buf[5][6:0], header_buf[6], header_buf[7], header_buf[8]};
					verdict = header_verdict();
					pay_off = '0;
					if (verdict != ST_CONTINUE) begin
						sticky = verdict;
						r.status = verdict;
					end else if (cur_len == '0) begin
						r.status = ST_READY;
					end else begin
						stage = STG_PAYLOAD;
					end
				end
			end
			r.frame_length = cur_len;
			r.frame_type = cur_type;
			r.frame_flags = cur_flags;
			r.frame_stream = cur_stream;
			expected_q.push_back(r);
		endfunction

		function void field_eq(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				if (errors <= PRINT_CAP)
					$display("%0t ns: %s expected %0h got %0h", $time, name, want, got);
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= PRINT_CAP)
					$display("%0t ns: result with nothing pending, expected none got status %0h",
						$time, got.status);
				return;
			end
			want = expected_q.pop_front();
			field_eq("status", 32'(want.status), 32'(got.status));
			field_eq("payload_valid", 32'(want.payload_valid), 32'(got.payload_valid));
			field_eq("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
			field_eq("payload_offset", 32'(want.payload_offset), 32'(got.payload_offset));
			field_eq("frame_length", 32'(want.frame_length), 32'(got.frame_length));
			field_eq("frame_type", 32'(want.frame_type), 32'(got.frame_type));
			field_eq("frame_flags", 32'(want.frame_flags), 32'(got.frame_flags));
			field_eq("frame_stream", 32'(want.frame_stream), 32'(got.frame_stream));
		endfunction
	endclass

endpackage

// ===== bench/http2_frame_deframer_core_test.sv =====
// self-checking bench for the http/2 frame deframer top level
module http2_frame_deframer_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import hfd_pkg::*;
	import deframe_check_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 1000000;
	localparam int unsigned TARGET_ITEMS = 950;
	localparam int unsigned MAX_BURST    = 64;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	logic                    clk;
	logic                    arst_n;
	logic                    push;
	logic                    full;
	logic [DATA_W-1:0]       data_byte;
	logic                    empty;
	logic                    pop;
	logic [2:0]              status;
	logic                    payload_valid;
	logic [DATA_W-1:0]       payload_byte;
	logic [LEN_W-1:0]        payload_offset;
	logic [LEN_W-1:0]        frame_length;
	logic [DATA_W-1:0]       frame_type;
	logic [DATA_W-1:0]       frame_flags;
	logic [STREAM_W-1:0]     frame_stream;
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_idx;
	logic [CFG_DATA_W-1:0]   cfg_wdata;

	frame_tracker      tracker;
	bit                steady = 1'b0;
	int unsigned       bytes_in = 0;
	int unsigned       cycles = 0;
	int unsigned       pop_hold = 0;
	logic [LEN_W-1:0]  cur_limit = LEN_W'(DEFAULT_LIMIT);

	http2_frame_deframer_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.data_byte      (data_byte),
		.empty          (empty),
		.pop            (pop),
		.status         (status),
		.payload_valid  (payload_valid),
		.payload_byte   (payload_byte),
		.payload_offset (payload_offset),
		.frame_length   (frame_length),
		.frame_type     (frame_type),
		.frame_flags    (frame_flags),
		.frame_stream   (frame_stream),
		.cfg_we         (cfg_we),
		.cfg_idx        (cfg_idx),
		.cfg_wdata      (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// mostly short gaps, a few long ones, none at all in steady phases
	function automatic int unsigned idle_len();
		int unsigned r;
		if (steady) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	initial begin
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (pop_hold != 0) begin
				pop <= 1'b0;
				pop_hold--;
			end else begin
				pop <= 1'b1;
				pop_hold = idle_len();
			end
		end
	end

	always @(posedge clk) begin : result_side
		result_t seen;
		if (arst_n && pop && !empty) begin
			seen.status = status_t'(status);
			seen.payload_valid = payload_valid;
			seen.payload_byte = payload_byte;
			seen.payload_offset = payload_offset;
			seen.frame_length = frame_length;
			seen.frame_type = frame_type;
			seen.frame_flags = frame_flags;
			seen.frame_stream = frame_stream;
			tracker.check_result(seen);
		end
	end

	// starts and ends at a falling edge, push left high for a back-to-back transaction
	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		gap = idle_len();
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (full) @(posedge clk);
		tracker.note_byte(b);
		bytes_in++;
		@(negedge clk);
	endtask

	task automatic send_header(input logic [LEN_W-1:0] len, input logic [7:0] ftype,
		input logic [7:0] flags, input bit rsv, input logic [STREAM_W-1:0] sid);
		send_byte(len[23:16]);
		send_byte(len[15:8]);
		send_byte(len[7:0]);
		send_byte(ftype);
		send_byte(flags);
		send_byte({rsv, sid[30:24]});
		send_byte(sid[23:16]);
		send_byte(sid[15:8]);
		send_byte(sid[7:0]);
	endtask

	task automatic settle();
		while (tracker.busy()) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		tracker.write_reg(idx, value);
		if (idx == REG_MAX_FRAME)
			cur_limit = (value == '0) ? LEN_W'(DEFAULT_LIMIT) : value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// mostly legal frames with random content, some with one rule broken, some oversized
	task automatic send_frame(output bit cut);
		int unsigned kind;
		int unsigned pick;
		int unsigned n;
		logic [7:0] ftype;
		logic [7:0] flags;
		logic [LEN_W-1:0] len;
		logic [STREAM_W-1:0] sid;
		bit rsv;
		kind = $urandom_range(0, 99);
		pick = $urandom_range(0, 10);
		ftype = (pick == 10) ? 8'($urandom_range(10, 255)) : 8'(pick);
		flags = 8'($urandom);
		rsv = 1'($urandom_range(0, 1));
		sid = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(1, 9));
		len = LEN_W'($urandom_range(0, 12));
		if ($urandom_range(0, 15) == 0) len = LEN_W'($urandom_range(13, 64));
		case (ftype)
			FT_PRIORITY: len = LEN_W'(5);
			FT_RST_STREAM, FT_WINDOW_UPDATE: len = LEN_W'(4);
			FT_PING: begin
				len = LEN_W'(8);
				sid = '0;
			end
			FT_GOAWAY: begin
				len = LEN_W'($urandom_range(8, 16));
				sid = '0;
			end
			FT_SETTINGS: begin
				sid = '0;
				len = flags[0] ? '0 : LEN_W'(6 * $urandom_range(0, 3));
			end
			default: ;
		endcase
		if (len > cur_limit) len = cur_limit;
		if (kind >= 75 && kind < 92) begin
			case ($urandom_range(0, 2))
				0: sid = (sid == '0) ? 31'($urandom_range(1, 1000)) : '0;
				1: len = LEN_W'($urandom_range(0, 20));
				default: ftype = 8'($urandom_range(0, 9));
			endcase
		end else if (kind >= 92) begin
			len = (cur_limit > 24'hFFFFF0) ? 24'hFFFFFF : cur_limit + LEN_W'($urandom_range(1, 3));
		end
		send_header(len, ftype, flags, rsv, sid);
		cut = 1'b0;
		if (tracker.stuck()) return;
		// a huge legal frame is only started; the next restart drops it
		n = (len > MAX_BURST) ? MAX_BURST : int'(len);
		cut = len > MAX_BURST;
		repeat (n) send_byte(8'($urandom));
	endtask

	task automatic run_phase(input int unsigned idx);
		int unsigned nframes;
		int unsigned bad_pos;
		logic [LEN_W-1:0] v;
		bit cut;
		settle();
		steady = ($urandom_range(0, 4) == 0);
		if ($urandom_range(0, 7) == 0)
			program_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 24'($urandom));
		if (idx < 4 || $urandom_range(0, 2) == 0) begin
			case (idx)
				0: v = 24'd1;
				1: v = 24'hFFFFFF;
				2: v = '0;
				3: v = LEN_W'(DEFAULT_LIMIT);
				default: case ($urandom_range(0, 5))
					0: v = 24'd1;
					1: v = 24'hFFFFFF;
					2: v = '0;
					3: v = LEN_W'($urandom_range(1, 64));
					4: v = LEN_W'($urandom_range(65, 40000));
					default: v = LEN_W'($urandom);
				endcase
			endcase
			program_reg(REG_MAX_FRAME, v);
		end
		program_reg(REG_PREFACE_REQ, {23'($urandom), 1'($urandom_range(0, 2) == 0)});
		cut = 1'b0;
		if (tracker.preface_on) begin
			bad_pos = ($urandom_range(0, 7) == 0) ? $urandom_range(0, PREFACE_LEN - 1) : PREFACE_LEN;
			for (int unsigned i = 0; i < PREFACE_LEN; i++) begin
				if (i == bad_pos)
					send_byte(preface_char(i) ^ 8'($urandom_range(1, 255)));
				else
					send_byte(preface_char(i));
				if (tracker.stuck()) break;
			end
		end
		nframes = $urandom_range(1, 8);
		for (int unsigned f = 0; f < nframes; f++) begin
			if (tracker.stuck() || cut) break;
			send_frame(cut);
		end
		// sometimes leave a header half gathered for the restart to clear
		if (!cut && !tracker.stuck() && $urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, HEADER_LEN - 1)) send_byte(8'($urandom));
		if (tracker.stuck())
			repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
		push <= 1'b0;
	endtask

	initial begin
		int unsigned phase;
		tracker = new();
		arst_n = 1'b0;
		push = 1'b0;
		data_byte = '0;
		cfg_we = 1'b0;
		cfg_idx = REG_PREFACE_REQ;
		cfg_wdata = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// defaults: empty settings ack with the reserved bit set, then data at the extremes
		send_header('0, FT_SETTINGS, FLAG_ACK, 1'b1, '0);
		send_header(24'd2, FT_DATA, 8'hFF, 1'b0, 31'h7FFFFFFF);
		send_byte(8'hFF);
		send_byte(8'h00);
		push <= 1'b0;
		settle();
		// preface on: one good byte, one wrong byte, then the error must hold
		program_reg(REG_PREFACE_REQ, 24'd1);
		send_byte(preface_char(0));
		send_byte(8'h00);
		send_byte(8'hAA);
		push <= 1'b0;

		phase = 0;
		while (bytes_in < TARGET_ITEMS) begin
			run_phase(phase);
			phase++;
		end
		settle();
		if (tracker.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
